// ===== sv/sdec_pkg.sv =====
// Package: shared constants, types and the exp2 mantissa table for the depth edge block.
package sdec_pkg;

  // Line memory sizing
  localparam int SDEC_MAX_WIDTH = 2048;

  // Configuration register file
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_FOCAL_LENGTH = 2'd2;

  localparam logic [11:0] RST_FRAME_WIDTH  = 12'd640;
  localparam logic [11:0] RST_FRAME_HEIGHT = 12'd480;
  localparam logic [12:0] RST_FOCAL_LENGTH = 13'd1000;
  localparam logic [11:0] MAX_HEIGHT       = 12'd2048;

  // Scale: floor(2^32 / 1000), then one correction step
  localparam logic [22:0] RECIP_1000 = 23'd4294967;
  // 5 * log2(e) in Q16: E/0.2 converted to log2 units
  localparam logic [18:0] CONF_MUL   = 19'd472740;
  localparam logic [20:0] E_CAP      = 21'd1048576;

  typedef logic [15:0] depth_t;
  typedef logic [15:0] conf_t;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_e;

  // round(65536 * 2^(-k/16)) for k = 0..16
  function automatic logic [16:0] exp2_mant(input logic [4:0] k);
    logic [16:0] v;
    case (k)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      5'd16:   v = 17'd32768;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/sdec_ifs.sv =====
// Interfaces: depth input channel and result channel with valid/ready handshakes.
interface sdec_in_if;
  import sdec_pkg::*;
  logic   valid;
  logic   ready;
  logic   command;
  depth_t depth_sample;
  modport source(output valid, command, depth_sample, input ready);
  modport sink(input valid, command, depth_sample, output ready);
endinterface

interface sdec_out_if;
  import sdec_pkg::*;
  logic   valid;
  logic   ready;
  depth_t depth_out;
  conf_t  confidence;
  logic   frame_end;
  logic   last_in_run;
  modport source(output valid, depth_out, confidence, frame_end, last_in_run, input ready);
  modport sink(input valid, depth_out, confidence, frame_end, last_in_run, output ready);
endinterface

// ===== sv/sdec_line_mem.sv =====
// Line memory: one write port, one read port, registered read data.
module sdec_line_mem #(
  parameter int DEPTH = sdec_pkg::SDEC_MAX_WIDTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);
  // {row r-2, row r-1} per column
  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// ===== sv/sobel_depth_edge_confidence_core.sv =====
// Top level: Sobel depth edge confidence with line memory and shared arithmetic sequencer.
//
// Usage:
//   in_ch carries one transaction per depth sample (command = pixel) or per drain
//   step (command = drain). out_ch carries scaled depth, Q0.16 confidence and
//   frame_end / last_in_run flags. Configuration goes over the APB port
//   (width at 0x0, height at 0x4, focal length at 0x8); write it only while idle.
//   Pixel (r-1, c-1) is produced when pixel (r, c) arrives; the last column of a
//   row adds a second result. After a frame's last pixel, send one drain per
//   pending bottom-row pixel. A pixel sent while drains are pending drops them.
// Sequence:
//   A pixel transaction runs the divider steps S_DIV1 and S_DIV2, S_PIX, then
//   S_G, S_SQ1, S_SQ2, S_T, S_M and S_C for its first result, and S_G to S_C again
//   for a second one; a drain runs S_DR1, S_DR2, S_DR3, then S_G to S_C; a drain
//   with nothing pending is taken in idle. New items wait while the block is busy.
// Reset: counters, window and output valid clear; line memory is not cleared.
// Stall: the output register holds a result until out_ch.ready; the sequencer
//   waits at the final stage while the register is still full.
module sobel_depth_edge_confidence_core #(
  parameter int MAX_WIDTH = sdec_pkg::SDEC_MAX_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  sdec_in_if.sink                       in_ch,
  sdec_out_if.source                    out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [sdec_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [sdec_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [sdec_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);
  import sdec_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_DIV1 = 13'b0000000000010,
    S_DIV2 = 13'b0000000000100,
    S_PIX  = 13'b0000000001000,
    S_DR1  = 13'b0000000010000,
    S_DR2  = 13'b0000000100000,
    S_DR3  = 13'b0000001000000,
    S_G    = 13'b0000010000000,
    S_SQ1  = 13'b0000100000000,
    S_SQ2  = 13'b0001000000000,
    S_T    = 13'b0010000000000,
    S_M    = 13'b0100000000000,
    S_C    = 13'b1000000000000
  } state_t;

  // Configuration registers
  logic [11:0] cfg_w_r, cfg_h_r;
  logic [12:0] cfg_f_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r <= RST_FRAME_WIDTH;
      cfg_h_r <= RST_FRAME_HEIGHT;
      cfg_f_r <= RST_FOCAL_LENGTH;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_FRAME_WIDTH:  cfg_w_r <= cfg_pwdata[11:0];
        REG_FRAME_HEIGHT: cfg_h_r <= cfg_pwdata[11:0];
        REG_FOCAL_LENGTH: cfg_f_r <= cfg_pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_FRAME_WIDTH:  cfg_prdata = {20'd0, cfg_w_r};
      REG_FRAME_HEIGHT: cfg_prdata = {20'd0, cfg_h_r};
      REG_FOCAL_LENGTH: cfg_prdata = {19'd0, cfg_f_r};
      default:          cfg_prdata = '0;
    endcase
  end

  // Effective frame size
  logic [WW-1:0] w_eff;
  logic [11:0]   h_eff;

  always_comb begin
    if (cfg_w_r < 12'd3) begin
      w_eff = WW'(3);
    end else if (int'(cfg_w_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_w_r);
    end
    if (cfg_h_r < 12'd3) begin
      h_eff = 12'd3;
    end else if (cfg_h_r > MAX_HEIGHT) begin
      h_eff = MAX_HEIGHT;
    end else begin
      h_eff = cfg_h_r;
    end
  end

  // Control state
  state_t        state_r, state_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [10:0]   row_r, row_nxt;
  logic [WW-1:0] pend_r, pend_nxt;
  logic          out_valid_r;

  // Datapath registers
  logic [29:0] prod_r, x_r;
  logic [20:0] qa_r;
  depth_t      s_r;
  logic [47:0] w0_r, w1_r, w2_r;
  logic [47:0] op_l_r, op_c_r, op_r_r;
  logic [CW-1:0] j_r;
  logic        pendb_r, last_r, fe_r;
  logic [17:0] ax_r, ay_r;
  logic [35:0] sqx_r;
  logic [20:0] e_r;
  logic [39:0] t_r;
  logic [16:0] tk_r;
  logic [27:0] dq_r;
  logic [7:0]  n_r;
  depth_t      depth_r;
  depth_t      out_depth_r;
  conf_t       out_conf_r;
  logic        out_fe_r, out_last_r;

  // Memory port
  logic          mem_we, mem_re;
  logic [CW-1:0] mem_raddr;
  logic [31:0]   mem_rdata;

  logic in_fire, out_load;
  logic col_last, row_last, emit_a, emit_b;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == S_C) && (!out_valid_r || out_ch.ready);
  assign col_last    = (WW'(col_r) + WW'(1)) >= w_eff;
  assign row_last    = ({1'b0, row_r} + 12'd1) >= h_eff;
  assign emit_a      = (row_r != 11'd0) && (col_r != '0);
  assign emit_b      = (row_r != 11'd0) && ((WW'(col_r) + WW'(1)) == w_eff);

  sdec_line_mem #(.DEPTH(MAX_WIDTH), .AW(CW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (col_r),
    .wdata ({mem_rdata[15:0], s_r}),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Sequencer and position counters
  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    pend_nxt  = pend_r;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_raddr = col_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_ch.command == CMD_DRAIN) begin
            if (pend_r != '0) begin
              state_nxt = S_DR1;
              pend_nxt  = pend_r - WW'(1);
              col_nxt   = (pend_r != WW'(1)) ? col_r + CW'(1) : '0;
              mem_re    = 1'b1;
              mem_raddr = col_r - CW'(1);
            end
          end else begin
            state_nxt = S_DIV1;
            mem_re    = 1'b1;
            if (pend_r != '0) begin
              // pixel during drain: restart the frame
              col_nxt   = '0;
              row_nxt   = '0;
              pend_nxt  = '0;
              mem_raddr = '0;
            end
          end
        end
      end
      S_DIV1: state_nxt = S_DIV2;
      S_DIV2: state_nxt = S_PIX;
      S_PIX: begin
        mem_we    = 1'b1;
        state_nxt = (emit_a || emit_b) ? S_G : S_IDLE;
        if (col_last) begin
          col_nxt = '0;
          if (row_last) begin
            row_nxt  = '0;
            pend_nxt = w_eff;
          end else begin
            row_nxt = row_r + 11'd1;
          end
        end else begin
          col_nxt = col_r + CW'(1);
        end
      end
      S_DR1: begin
        mem_re    = 1'b1;
        mem_raddr = j_r;
        state_nxt = S_DR2;
      end
      S_DR2: begin
        mem_re    = 1'b1;
        mem_raddr = j_r + CW'(1);
        state_nxt = S_DR3;
      end
      S_DR3: state_nxt = S_G;
      S_G:   state_nxt = S_SQ1;
      S_SQ1: state_nxt = S_SQ2;
      S_SQ2: state_nxt = S_T;
      S_T:   state_nxt = S_M;
      S_M:   state_nxt = S_C;
      S_C: begin
        if (out_load) begin
          state_nxt = pendb_r ? S_G : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
      w0_r        <= '0;
      w1_r        <= '0;
      w2_r        <= '0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      pend_r  <= pend_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      // window shift on each pixel
      if (state_r == S_PIX) begin
        w0_r <= (col_r == '0) ? 48'd0 : w1_r;
        w1_r <= (col_r == '0) ? 48'd0 : w2_r;
        w2_r <= {(row_r >= 11'd2) ? mem_rdata[31:16] : 16'd0,
                 (row_r >= 11'd1) ? mem_rdata[15:0]  : 16'd0, s_r};
      end
    end
  end

  // Datapath combinational terms
  logic [29:0] x_c;
  logic [52:0] qmul_c;
  logic [30:0] rem_c;
  logic [21:0] qs_c;
  logic [47:0] nw0_c, nw1_c, nw2_c;
  logic [17:0] ls_c, rs_c, ts_c, bs_c;
  logic [18:0] gx_c, gy_c;
  logic [36:0] e_c;
  logic [16:0] tk1_c, m_c;
  logic [17:0] half_c, v_c;
  conf_t       conf_c;

  always_comb begin
    x_c    = prod_r + 30'd500;
    qmul_c = 53'(x_c) * 53'(RECIP_1000);
    rem_c  = 31'(x_r) - 31'(qa_r) * 31'd1000;
    qs_c   = (rem_c >= 31'd1000) ? 22'(qa_r) + 22'd1 : 22'(qa_r);

    nw0_c = (col_r == '0) ? 48'd0 : w1_r;
    nw1_c = (col_r == '0) ? 48'd0 : w2_r;
    nw2_c = {(row_r >= 11'd2) ? mem_rdata[31:16] : 16'd0,
             (row_r >= 11'd1) ? mem_rdata[15:0]  : 16'd0, s_r};

    // Sobel: x across columns, y across rows
    rs_c = 18'(op_r_r[47:32]) + {1'b0, op_r_r[31:16], 1'b0} + 18'(op_r_r[15:0]);
    ls_c = 18'(op_l_r[47:32]) + {1'b0, op_l_r[31:16], 1'b0} + 18'(op_l_r[15:0]);
    bs_c = 18'(op_l_r[15:0]) + {1'b0, op_c_r[15:0], 1'b0} + 18'(op_r_r[15:0]);
    ts_c = 18'(op_l_r[47:32]) + {1'b0, op_c_r[47:32], 1'b0} + 18'(op_r_r[47:32]);
    gx_c = {1'b0, rs_c} - {1'b0, ls_c};
    gy_c = {1'b0, bs_c} - {1'b0, ts_c};

    e_c = 37'(sqx_r) + 37'(ay_r) * 37'(ay_r);

    tk1_c  = exp2_mant({1'b0, t_r[31:28]} + 5'd1);
    m_c    = tk_r - 17'((29'(dq_r) + 29'd32768) >> 16);
    half_c = (n_r == 8'd0) ? 18'd0 : (18'd1 << (n_r[4:0] - 5'd1));
    v_c    = ({1'b0, m_c} + half_c) >> n_r[4:0];
    if (n_r >= 8'd17) begin
      conf_c = '0;
    end else if (v_c > 18'd65535) begin
      conf_c = 16'hFFFF;
    end else begin
      conf_c = v_c[15:0];
    end
  end

  // Datapath registers, loaded by sequencer step
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        prod_r <= 30'(in_ch.depth_sample) * 30'(cfg_f_r);
        j_r    <= col_r;
        fe_r   <= (pend_r == WW'(1));
        last_r <= 1'b1;
        pendb_r <= 1'b0;
      end
      S_DIV1: begin
        x_r  <= x_c;
        qa_r <= qmul_c[52:32];
      end
      S_DIV2: s_r <= (qs_c > 22'd65535) ? 16'hFFFF : qs_c[15:0];
      S_PIX: begin
        fe_r    <= 1'b0;
        pendb_r <= emit_a && emit_b;
        last_r  <= !(emit_a && emit_b);
        if (emit_a) begin
          op_l_r <= nw0_c;
          op_c_r <= nw1_c;
          op_r_r <= nw2_c;
        end else begin
          op_l_r <= nw1_c;
          op_c_r <= nw2_c;
          op_r_r <= '0;
        end
      end
      S_DR1: op_l_r <= ((j_r != '0) && (WW'(j_r) <= w_eff)) ? {mem_rdata, 16'd0} : '0;
      S_DR2: op_c_r <= (WW'(j_r) < w_eff) ? {mem_rdata, 16'd0} : '0;
      S_DR3: op_r_r <= ((WW'(j_r) + WW'(1)) < w_eff) ? {mem_rdata, 16'd0} : '0;
      S_G: begin
        ax_r    <= gx_c[18] ? 18'(-gx_c) : gx_c[17:0];
        ay_r    <= gy_c[18] ? 18'(-gy_c) : gy_c[17:0];
        depth_r <= op_c_r[31:16];
      end
      S_SQ1: sqx_r <= ax_r * ax_r;
      S_SQ2: e_r <= (e_c > 37'(E_CAP)) ? E_CAP : e_c[20:0];
      S_T:   t_r <= 40'(e_r) * 40'(CONF_MUL);
      S_M: begin
        tk_r <= exp2_mant({1'b0, t_r[31:28]});
        dq_r <= 28'(12'(exp2_mant({1'b0, t_r[31:28]}) - tk1_c)) * 28'(t_r[27:12]);
        n_r  <= t_r[39:32];
      end
      S_C: begin
        if (out_load) begin
          out_depth_r <= depth_r;
          out_conf_r  <= conf_c;
          out_fe_r    <= fe_r;
          out_last_r  <= last_r;
          if (pendb_r) begin
            // right-edge result uses zero padding on the right
            op_l_r  <= w1_r;
            op_c_r  <= w2_r;
            op_r_r  <= '0;
            pendb_r <= 1'b0;
            last_r  <= 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.depth_out   = out_depth_r;
  assign out_ch.confidence  = out_conf_r;
  assign out_ch.frame_end   = out_fe_r;
  assign out_ch.last_in_run = out_last_r;

  // Checks
  a_mem_write_in_pix: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> state_r == S_PIX)
    else $error("line memory written outside pixel step");

  a_reset_clears: assert property (@(posedge clk)
    $past(!rst_n) |-> (col_r == '0 && pend_r == '0 && row_r == '0))
    else $error("counters not cleared by reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_C && out_valid_r && !out_ch.ready) |=> state_r == S_C)
    else $error("sequencer left final stage while output full");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_IDLE || state_r == S_DIV1 || state_r == S_DR1))
    else $error("unexpected state after input transaction");
endmodule

// ===== sim/sdec_tb_checker.sv =====
// Checker: watches the depth and result channels, predicts results and compares them.
`timescale 1ns / 100ps

module sdec_tb_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  sdec_in_if                            in_mon,
  sdec_out_if                           out_mon,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic                          cfg_pready,
  input  logic [sdec_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [sdec_pkg::CFG_DW-1:0]   cfg_pwdata,
  output int                            err_count,
  output int                            results_waiting,
  output int                            results_seen
);
  import sdec_pkg::*;

  typedef struct packed {
    depth_t depth;
    conf_t  conf;
    logic   frame_end;
    logic   last_in_run;
  } edge_result_t;

  // 2^(-k/16) in Q16
  localparam int unsigned EXP2_Q16 [17] = '{
    65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393, 46341,
    44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};

  edge_result_t expected_q[$];

  // shadow of the block's state and registers
  logic [15:0] row_above [SDEC_MAX_WIDTH];
  logic [15:0] row_mid   [SDEC_MAX_WIDTH];
  logic [47:0] win [3];
  int unsigned col_pos, row_pos, drains_left;
  logic [11:0] width_reg, height_reg;
  logic [12:0] focal_reg;

  function automatic int unsigned eff_w();
    int unsigned v;
    v = width_reg;
    if (v < 3) v = 3;
    if (v > SDEC_MAX_WIDTH) v = SDEC_MAX_WIDTH;
    return v;
  endfunction

  function automatic int unsigned eff_h();
    int unsigned v;
    v = height_reg;
    if (v < 3) v = 3;
    if (v > 2048) v = 2048;
    return v;
  endfunction

  // exp(-E/0.2) in Q0.16 via piecewise-linear exp2
  function automatic conf_t edge_conf(logic [47:0] l, logic [47:0] c, logic [47:0] r);
    longint gx, gy, e;
    longint unsigned t, n, f, k, q, m, v;
    gx = longint'(r[47:32]) + 2 * longint'(r[31:16]) + longint'(r[15:0])
       - longint'(l[47:32]) - 2 * longint'(l[31:16]) - longint'(l[15:0]);
    gy = longint'(l[15:0]) + 2 * longint'(c[15:0]) + longint'(r[15:0])
       - longint'(l[47:32]) - 2 * longint'(c[47:32]) - longint'(r[47:32]);
    if (gx < 0) gx = -gx;
    if (gy < 0) gy = -gy;
    e = gx * gx + gy * gy;
    if (e > (64'd1 << 20)) e = 64'd1 << 20;
    t = longint'(e) * 5 * 94548;
    n = t >> 32;
    if (n >= 17) return '0;
    f = t & 64'hFFFF_FFFF;
    k = f >> 28;
    q = (f >> 12) & 64'hFFFF;
    m = EXP2_Q16[k] - (((EXP2_Q16[k] - EXP2_Q16[k+1]) * q + 32768) >> 16);
    v = (m + ((64'd1 << n) >> 1)) >> n;
    if (v > 65535) v = 65535;
    return conf_t'(v);
  endfunction

  function automatic logic [47:0] stored_column(int unsigned j, int unsigned w);
    if (j >= w || j >= SDEC_MAX_WIDTH) return '0;
    return {row_above[j], row_mid[j], 16'd0};
  endfunction

  task automatic push_result(logic [47:0] l, logic [47:0] c, logic [47:0] r, logic fe,
                             logic lir);
    edge_result_t x;
    x.depth = c[31:16];
    x.conf = edge_conf(l, c, r);
    x.frame_end = fe;
    x.last_in_run = lir;
    expected_q = {expected_q, x};
  endtask

  // advance the shadow state by one input transaction
  task automatic predict_step(logic cmd, depth_t d);
    int unsigned w, h, j;
    longint unsigned s;
    logic [15:0] a, mid;
    logic [47:0] l, c, r;
    w = eff_w();
    h = eff_h();
    if (cmd == CMD_DRAIN) begin
      if (drains_left == 0) return;
      j = col_pos;
      l = (j >= 1) ? stored_column(j - 1, w) : '0;
      c = stored_column(j, w);
      r = stored_column(j + 1, w);
      push_result(l, c, r, drains_left == 1, 1'b1);
      drains_left--;
      col_pos = drains_left ? j + 1 : 0;
    end else begin
      if (drains_left != 0) begin
        drains_left = 0;
        col_pos = 0;
        row_pos = 0;
      end
      s = (longint'(d) * focal_reg + 500) / 1000;
      if (s > 65535) s = 65535;
      a = 16'd0;
      mid = 16'd0;
      if (col_pos < SDEC_MAX_WIDTH) begin
        a = row_above[col_pos];
        mid = row_mid[col_pos];
      end
      if (col_pos == 0) begin
        win[0] = '0;
        win[1] = '0;
      end else begin
        win[0] = win[1];
        win[1] = win[2];
      end
      win[2] = {(row_pos >= 2) ? a : 16'd0, (row_pos >= 1) ? mid : 16'd0, s[15:0]};
      if (col_pos < SDEC_MAX_WIDTH) begin
        row_above[col_pos] = mid;
        row_mid[col_pos] = s[15:0];
      end
      if (row_pos >= 1 && col_pos >= 1)
        push_result(win[0], win[1], win[2], 1'b0, !(col_pos == w - 1));
      if (row_pos >= 1 && col_pos == w - 1)
        push_result(win[1], win[2], '0, 1'b0, 1'b1);
      if (col_pos + 1 >= w) begin
        col_pos = 0;
        if (row_pos + 1 >= h) begin
          row_pos = 0;
          drains_left = w;
        end else begin
          row_pos++;
        end
      end else begin
        col_pos++;
      end
    end
  endtask

  task automatic check_result();
    edge_result_t x;
    results_seen++;
    if (expected_q.size() == 0) begin
      err_count++;
      if (err_count <= 10)
        $display("%0t: unexpected result depth=%h conf=%h", $realtime,
                 out_mon.depth_out, out_mon.confidence);
      return;
    end
    x = expected_q.pop_front();
    if (x.depth !== out_mon.depth_out || x.conf !== out_mon.confidence ||
        x.frame_end !== out_mon.frame_end || x.last_in_run !== out_mon.last_in_run) begin
      err_count++;
      if (err_count <= 10)
        $display("%0t: mismatch exp depth=%h conf=%h fe=%b lir=%b got %h %h %b %b",
                 $realtime, x.depth, x.conf, x.frame_end, x.last_in_run,
                 out_mon.depth_out, out_mon.confidence, out_mon.frame_end,
                 out_mon.last_in_run);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (win[i]) win[i] = '0;
      col_pos = 0;
      row_pos = 0;
      drains_left = 0;
      width_reg = RST_FRAME_WIDTH;
      height_reg = RST_FRAME_HEIGHT;
      focal_reg = RST_FOCAL_LENGTH;
      expected_q.delete();
    end else begin
      // register write at the access phase
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          REG_FRAME_WIDTH:  width_reg = cfg_pwdata[11:0];
          REG_FRAME_HEIGHT: height_reg = cfg_pwdata[11:0];
          REG_FOCAL_LENGTH: focal_reg = cfg_pwdata[12:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        predict_step(in_mon.command, in_mon.depth_sample);
      if (out_mon.valid && out_mon.ready)
        check_result();
    end
    results_waiting = expected_q.size();
  end

endmodule

// ===== sim/tb_sobel_depth_edge_confidence_core.sv =====
// Testbench top: stimulus, receiver stalls, configuration writes and the verdict.
`timescale 1ns / 100ps

module tb_sobel_depth_edge_confidence_core;
  import sdec_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE = 40;
  localparam int HOLD_LEN = 300;

  logic clk;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;

  int err_count, results_waiting, results_seen;
  int pixels_sent, drains_sent, frames_sent;
  int hold_reqs, holds_done, idle_cycles, burst_left;

  sdec_in_if  in_ch ();
  sdec_out_if out_ch ();

  sobel_depth_edge_confidence_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  sdec_tb_checker chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_pready(cfg_pready), .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .err_count(err_count), .results_waiting(results_waiting),
    .results_seen(results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog: cycles with no transaction of any kind
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_psel && cfg_penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: stall pattern re-chosen at random from four modes, plus long holds on request
  initial begin
    int cyc, mode, hold_cnt;
    out_ch.ready <= 1'b0;
    cyc = 0;
    mode = 0;
    hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_done) begin
        holds_done = hold_reqs;
        hold_cnt = HOLD_LEN;
      end
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      cyc++;
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= $urandom_range(0, 1);
          2: out_ch.ready <= ($urandom_range(0, 7) != 0);
          default: out_ch.ready <= (cyc % 3 == 0);
        endcase
      end
    end
  end

  // one transaction on the depth channel; valid stays high across back-to-back items
  task automatic send_item(logic cmd, depth_t d);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.depth_sample <= d;
    do @(posedge clk); while (!in_ch.ready);
    if (cmd == CMD_DRAIN) drains_sent++;
    else pixels_sent++;
  endtask

  task automatic wait_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_waiting != 0) @(posedge clk);
  endtask

  // configuration only once the block has drained and gone quiet
  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    wait_results();
    repeat (SETTLE) @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= CFG_AW'({idx, 2'b00});
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic set_frame(int w, int h, int f);
    reg_write(REG_FRAME_WIDTH, w);
    reg_write(REG_FRAME_HEIGHT, h);
    reg_write(REG_FOCAL_LENGTH, f);
  endtask

  function automatic depth_t pick_depth(int style, depth_t base);
    case (style)
      0: return depth_t'($urandom());
      1: return base + depth_t'($urandom_range(0, 63));
      2: return base;
      default: return ($urandom_range(0, 1)) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  // one frame of w x h pixels; drain_mode 0 full (+extra), 1 partial, 2 none
  task automatic send_frame(int w, int h, int style, int drain_mode);
    depth_t base;
    int n;
    base = depth_t'($urandom());
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++) begin
        // stray drains find nothing pending once the frame's first pixel is in
        if ($urandom_range(0, 40) == 0) send_item(CMD_DRAIN, depth_t'($urandom()));
        send_item(CMD_PIXEL, pick_depth(style, base));
      end
    frames_sent++;
    case (drain_mode)
      0: n = w + $urandom_range(0, 2);
      1: n = $urandom_range(1, w - 1);
      default: n = 0;
    endcase
    for (int i = 0; i < n; i++) send_item(CMD_DRAIN, depth_t'($urandom()));
  endtask

  initial begin
    int w, h, f, rnd_items;
    rst_n = 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.command <= CMD_PIXEL;
    in_ch.depth_sample <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    pixels_sent = 0;
    drains_sent = 0;
    frames_sent = 0;
    hold_reqs = 0;
    burst_left = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: drain on an empty block, extreme depths, overdrain, discard
    set_frame(3, 3, 1000);
    send_item(CMD_DRAIN, 16'hFFFF);
    send_frame(3, 3, 3, 0);
    send_frame(3, 3, 3, 1);
    send_frame(3, 3, 0, 0);
    // out-of-range sizes clamp, zero focal length gives zero depth
    set_frame(1, 0, 0);
    hold_reqs++;
    send_frame(3, 3, 0, 0);
    // wide row, largest focal length
    set_frame(120, 3, 8191);
    send_frame(120, 3, 1, 0);
    // tall frame, smallest nonzero focal length
    set_frame(3, 100, 1);
    send_frame(3, 100, 1, 0);
    set_frame(2048, 4095, 8191);
    set_frame(3, 3, 1000);
    send_frame(3, 3, 0, 2);
    send_frame(3, 3, 1, 0);

    // random phases with mostly small frames
    rnd_items = 0;
    while (rnd_items < 1000) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(3, 12);
      h = $urandom_range(3, 6);
      case ($urandom_range(0, 5))
        0: f = 8191;
        1: f = $urandom_range(0, 10);
        default: f = $urandom_range(1, 8191);
      endcase
      set_frame(w, h, f);
      if ($urandom_range(0, 4) == 0) hold_reqs++;
      repeat ($urandom_range(1, 3)) begin
        send_frame(w, h, $urandom_range(0, 3), $urandom_range(0, 2));
        rnd_items += w * h;
        if ($urandom_range(0, 3) == 0) wait_results();
      end
      // leave no drains pending across a register change
      send_frame(w, h, 1, 0);
      rnd_items += w * h;
    end

    wait_results();
    repeat (SETTLE) @(posedge clk);
    $display("Covered %0d frames: %0d pixels, %0d drain steps, %0d results checked.",
             frames_sent, pixels_sent, drains_sent, results_seen);
    $display("Included clamped sizes, zero and max focal length, overdrain and discards.");
    if (err_count == 0 && results_waiting == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
